// ----- design/pcm_pkg.sv -----
// shared constants, payload types and codes for the path corridor merge block
package pcm_pkg;

  localparam int PathDepth = 256;
  localparam int AddrW     = $clog2(PathDepth);
  localparam int CntW      = AddrW + 1;
  localparam int VisDepth  = 16;
  localparam int VisIdxW   = $clog2(VisDepth);
  localparam int VisCntW   = VisIdxW + 1;
  localparam int RefW      = 32;

  localparam logic [CntW-1:0] MaxPathReset = CntW'(PathDepth);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_PUSH   = 2'd2,
    CMD_READ   = 2'd3
  } pcm_cmd_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_PATH_FULL  = 3'd1,
    STAT_VIS_FULL   = 3'd2,
    STAT_READ_RANGE = 3'd3,
    STAT_NO_COMMON  = 3'd4
  } pcm_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SETUP,
    S_MOVE,
    S_FILL,
    S_FINISH
  } pcm_state_e;

  typedef struct packed {
    pcm_cmd_e    cmd;
    logic [31:0] poly_ref;
    logic        last;
    logic [7:0]  index;
  } pcm_in_t;

  typedef struct packed {
    logic [8:0]  path_length;
    logic [31:0] read_ref;
    pcm_status_e status;
  } pcm_out_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [RefW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } pcm_ram_req_t;

endpackage

// ----- design/pcm_corridor_ram.sv -----
// corridor memory: one write port, one read port, registered read data
module pcm_corridor_ram (
  input  logic                        clk_i,
  input  pcm_pkg::pcm_ram_req_t       req_i,
  output logic [pcm_pkg::RefW-1:0]    rd_data_o
);

  logic [pcm_pkg::RefW-1:0] mem [pcm_pkg::PathDepth];
  logic [pcm_pkg::RefW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/pcm_out_fifo.sv -----
// two-entry result buffer between the controller and the output channel
module pcm_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pcm_pkg::pcm_out_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pcm_pkg::pcm_out_t out_data_o
);

  pcm_pkg::pcm_out_t slot_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign full_o      = (cnt_q == 2'd2);

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/pcm_ctrl.sv -----
// command decode, visited list, and the scan/move/fill merge sequencer
module pcm_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pcm_pkg::pcm_in_t                in_data_i,
  input  logic                            cfg_valid_i,
  input  logic [8:0]                      cfg_data_i,
  output pcm_pkg::pcm_ram_req_t           ram_req_o,
  input  logic [pcm_pkg::RefW-1:0]        ram_rdata_i,
  input  logic                            fifo_full_i,
  output logic                            res_push_o,
  output pcm_pkg::pcm_out_t               res_data_o
);

  localparam int CntW    = pcm_pkg::CntW;
  localparam int AddrW   = pcm_pkg::AddrW;
  localparam int VisCntW = pcm_pkg::VisCntW;
  localparam int VisIdxW = pcm_pkg::VisIdxW;
  localparam int SumW    = CntW + 1;

  pcm_pkg::pcm_state_e state_q, state_d;

  logic [CntW-1:0]          count_q, count_d;
  logic [VisCntW-1:0]       vcount_q, vcount_d;
  logic [CntW-1:0]          max_path_q;
  logic [pcm_pkg::RefW-1:0] visited_q [pcm_pkg::VisDepth];
  logic                     rd_oor_q, rd_oor_d;
  logic                     vis_full_q, vis_full_d;
  logic                     found_q, found_d;
  logic [AddrW-1:0]         chk_pos_q, chk_pos_d;
  logic                     chk_vld_q, chk_vld_d;
  logic [AddrW-1:0]         fp_q, fp_d;
  logic [VisIdxW-1:0]       fv_q, fv_d;
  logic [CntW-1:0]          total_q, total_d;
  logic [CntW-1:0]          mv_cnt_q, mv_cnt_d;
  logic [AddrW-1:0]         src_q, src_d;
  logic [AddrW-1:0]         dst_q, dst_d;
  logic                     mv_up_q, mv_up_d;
  logic                     wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]         wdst_q, wdst_d;
  logic [VisCntW-1:0]       fill_cnt_q, fill_cnt_d;
  logic [AddrW-1:0]         fill_k_q, fill_k_d;
  logic [VisIdxW-1:0]       vidx_q, vidx_d;

  logic                     accept;
  logic                     vis_full_now;
  logic                     vis_we;
  logic [pcm_pkg::VisDepth-1:0] hit_vec;
  logic                     any_hit;
  logic [VisIdxW-1:0]       hit_idx;
  logic                     scan_hit, scan_end;
  logic [AddrW-1:0]         scan_addr;

  // merge geometry
  logic [VisCntW-1:0] req;
  logic [CntW-1:0]    orig, tail, limit, total, ntail;
  logic [SumW-1:0]    sum;
  logic [VisCntW-1:0] nvis;
  logic               mv_up, mv_same;

  assign in_stall_o   = (state_q != pcm_pkg::S_IDLE) || fifo_full_i;
  assign accept       = in_valid_i && !in_stall_o;
  assign vis_full_now = (vcount_q == VisCntW'(pcm_pkg::VisDepth));
  assign vis_we       = accept && (in_data_i.cmd == pcm_pkg::CMD_PUSH) && !vis_full_now;

  // compare the returned corridor entry against every stored visited entry
  always_comb begin
    for (int j = 0; j < pcm_pkg::VisDepth; j++) begin
      hit_vec[j] = (VisCntW'(j) < vcount_q) && (visited_q[j] == ram_rdata_i);
    end
    hit_idx = '0;
    for (int j = pcm_pkg::VisDepth - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_idx = VisIdxW'(j);
      end
    end
    any_hit = |hit_vec;
  end

  assign scan_hit  = chk_vld_q && any_hit;
  assign scan_end  = chk_vld_q && !any_hit && (chk_pos_q == '0);
  assign scan_addr = chk_vld_q ? (chk_pos_q - AddrW'(1)) : AddrW'(count_q - CntW'(1));

  always_comb begin
    req     = vcount_q - VisCntW'(fv_q);
    orig    = CntW'(fp_q) + CntW'(1);
    tail    = count_q - orig;
    sum     = SumW'(req) + SumW'(tail);
    limit   = (max_path_q > CntW'(pcm_pkg::PathDepth)) ? CntW'(pcm_pkg::PathDepth)
                                                       : max_path_q;
    total   = (sum > SumW'(limit)) ? limit : CntW'(sum);
    ntail   = (total > CntW'(req)) ? (total - CntW'(req)) : '0;
    nvis    = (total < CntW'(req)) ? VisCntW'(total) : req;
    mv_up   = CntW'(req) > orig;
    mv_same = CntW'(req) == orig;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.cmd)
            pcm_pkg::CMD_READ: state_d = pcm_pkg::S_READ;
            pcm_pkg::CMD_PUSH: begin
              if (in_data_i.last) begin
                state_d = (count_q == '0) ? pcm_pkg::S_FINISH : pcm_pkg::S_SCAN;
              end
            end
            default: state_d = pcm_pkg::S_IDLE;
          endcase
        end
      end
      pcm_pkg::S_READ: state_d = pcm_pkg::S_IDLE;
      pcm_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_d = pcm_pkg::S_SETUP;
        end else if (scan_end) begin
          state_d = pcm_pkg::S_FINISH;
        end
      end
      pcm_pkg::S_SETUP: state_d = pcm_pkg::S_MOVE;
      pcm_pkg::S_MOVE: begin
        if (mv_cnt_q == '0 && !wr_pend_q) begin
          state_d = pcm_pkg::S_FILL;
        end
      end
      pcm_pkg::S_FILL: begin
        if (fill_cnt_q == '0) begin
          state_d = pcm_pkg::S_FINISH;
        end
      end
      pcm_pkg::S_FINISH: state_d = pcm_pkg::S_IDLE;
      default: state_d = pcm_pkg::S_IDLE;
    endcase
  end

  // outputs: memory port and result beat
  always_comb begin
    ram_req_o              = '0;
    res_push_o             = 1'b0;
    res_data_o.path_length = count_q;
    res_data_o.read_ref    = '0;
    res_data_o.status      = pcm_pkg::STAT_OK;
    unique case (state_q)
      pcm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.cmd)
            pcm_pkg::CMD_CLEAR: begin
              res_push_o             = 1'b1;
              res_data_o.path_length = '0;
            end
            pcm_pkg::CMD_APPEND: begin
              res_push_o = 1'b1;
              if (count_q < CntW'(pcm_pkg::PathDepth)) begin
                ram_req_o.we           = 1'b1;
                ram_req_o.waddr        = AddrW'(count_q);
                ram_req_o.wdata        = in_data_i.poly_ref;
                res_data_o.path_length = count_q + CntW'(1);
              end else begin
                res_data_o.status = pcm_pkg::STAT_PATH_FULL;
              end
            end
            pcm_pkg::CMD_PUSH: begin
              if (!in_data_i.last) begin
                res_push_o = 1'b1;
                if (vis_full_now) begin
                  res_data_o.status = pcm_pkg::STAT_VIS_FULL;
                end
              end
            end
            pcm_pkg::CMD_READ: begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = in_data_i.index;
            end
            default: ram_req_o = '0;
          endcase
        end
      end
      pcm_pkg::S_READ: begin
        res_push_o = 1'b1;
        if (rd_oor_q) begin
          res_data_o.status = pcm_pkg::STAT_READ_RANGE;
        end else begin
          res_data_o.read_ref = ram_rdata_i;
        end
      end
      pcm_pkg::S_SCAN: begin
        if (!scan_hit && !scan_end) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = scan_addr;
        end
      end
      pcm_pkg::S_MOVE: begin
        if (wr_pend_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = wdst_q;
          ram_req_o.wdata = ram_rdata_i;
        end
        if (mv_cnt_q != '0) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = src_q;
        end
      end
      pcm_pkg::S_FILL: begin
        if (fill_cnt_q != '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = fill_k_q;
          ram_req_o.wdata = visited_q[vidx_q];
        end
      end
      pcm_pkg::S_FINISH: begin
        res_push_o = 1'b1;
        if (found_q) begin
          res_data_o.path_length = total_q;
        end
        if (vis_full_q) begin
          res_data_o.status = pcm_pkg::STAT_VIS_FULL;
        end else if (!found_q) begin
          res_data_o.status = pcm_pkg::STAT_NO_COMMON;
        end
      end
      default: res_push_o = 1'b0;
    endcase
  end

  // datapath registers
  always_comb begin
    count_d    = count_q;
    vcount_d   = vcount_q;
    rd_oor_d   = rd_oor_q;
    vis_full_d = vis_full_q;
    found_d    = found_q;
    chk_pos_d  = chk_pos_q;
    chk_vld_d  = chk_vld_q;
    fp_d       = fp_q;
    fv_d       = fv_q;
    total_d    = total_q;
    mv_cnt_d   = mv_cnt_q;
    src_d      = src_q;
    dst_d      = dst_q;
    mv_up_d    = mv_up_q;
    wr_pend_d  = wr_pend_q;
    wdst_d     = wdst_q;
    fill_cnt_d = fill_cnt_q;
    fill_k_d   = fill_k_q;
    vidx_d     = vidx_q;
    unique case (state_q)
      pcm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.cmd)
            pcm_pkg::CMD_CLEAR: count_d = '0;
            pcm_pkg::CMD_APPEND: begin
              if (count_q < CntW'(pcm_pkg::PathDepth)) begin
                count_d = count_q + CntW'(1);
              end
            end
            pcm_pkg::CMD_PUSH: begin
              if (!vis_full_now) begin
                vcount_d = vcount_q + VisCntW'(1);
              end
              vis_full_d = vis_full_now;
              found_d    = 1'b0;
              chk_vld_d  = 1'b0;
            end
            pcm_pkg::CMD_READ: rd_oor_d = ({1'b0, in_data_i.index} >= count_q);
            default: count_d = count_q;
          endcase
        end
      end
      pcm_pkg::S_SCAN: begin
        if (scan_hit) begin
          fp_d = chk_pos_q;
          fv_d = hit_idx;
        end else if (!scan_end) begin
          chk_pos_d = scan_addr;
          chk_vld_d = 1'b1;
        end
      end
      pcm_pkg::S_SETUP: begin
        found_d    = 1'b1;
        total_d    = total;
        mv_cnt_d   = mv_same ? '0 : ntail;
        mv_up_d    = mv_up;
        src_d      = mv_up ? AddrW'(orig + ntail - CntW'(1)) : AddrW'(orig);
        dst_d      = mv_up ? AddrW'(total - CntW'(1)) : AddrW'(req);
        wr_pend_d  = 1'b0;
        fill_cnt_d = nvis;
        fill_k_d   = '0;
        vidx_d     = VisIdxW'(vcount_q - VisCntW'(1));
      end
      pcm_pkg::S_MOVE: begin
        if (mv_cnt_q != '0) begin
          wr_pend_d = 1'b1;
          wdst_d    = dst_q;
          mv_cnt_d  = mv_cnt_q - CntW'(1);
          src_d     = mv_up_q ? (src_q - AddrW'(1)) : (src_q + AddrW'(1));
          dst_d     = mv_up_q ? (dst_q - AddrW'(1)) : (dst_q + AddrW'(1));
        end else begin
          wr_pend_d = 1'b0;
        end
      end
      pcm_pkg::S_FILL: begin
        if (fill_cnt_q != '0) begin
          fill_cnt_d = fill_cnt_q - VisCntW'(1);
          fill_k_d   = fill_k_q + AddrW'(1);
          vidx_d     = vidx_q - VisIdxW'(1);
        end
      end
      pcm_pkg::S_FINISH: begin
        if (found_q) begin
          count_d = total_q;
        end
        vcount_d = '0;
      end
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pcm_pkg::S_IDLE;
      count_q    <= '0;
      vcount_q   <= '0;
      max_path_q <= pcm_pkg::MaxPathReset;
      rd_oor_q   <= 1'b0;
      vis_full_q <= 1'b0;
      found_q    <= 1'b0;
      chk_vld_q  <= 1'b0;
      mv_cnt_q   <= '0;
      mv_up_q    <= 1'b0;
      wr_pend_q  <= 1'b0;
      fill_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      vcount_q   <= vcount_d;
      rd_oor_q   <= rd_oor_d;
      vis_full_q <= vis_full_d;
      found_q    <= found_d;
      chk_vld_q  <= chk_vld_d;
      mv_cnt_q   <= mv_cnt_d;
      mv_up_q    <= mv_up_d;
      wr_pend_q  <= wr_pend_d;
      fill_cnt_q <= fill_cnt_d;
      if (cfg_valid_i) begin
        max_path_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_pos_q <= chk_pos_d;
    fp_q      <= fp_d;
    fv_q      <= fv_d;
    total_q   <= total_d;
    src_q     <= src_d;
    dst_q     <= dst_d;
    wdst_q    <= wdst_d;
    fill_k_q  <= fill_k_d;
    vidx_q    <= vidx_d;
    if (vis_we) begin
      visited_q[vcount_q[VisIdxW-1:0]] <= in_data_i.poly_ref;
    end
  end

endmodule

// ----- design/path_corridor_merge.sv -----
// top level of the path corridor merge block
//
//  channel  direction  handshake              beat
//  in       input      in_valid_i/in_stall_o  cmd, poly_ref, last, index
//  out      output     out_valid_o/out_stall_i path_length, read_ref, status
//  cfg      input      cfg_valid_i/cfg_ready_o max_path (9 bits)
//
//  clear, append and non-last push answer when taken; a read waits on registered read data
//  a last push merges: the corridor memory is scanned one entry a cycle from the end,
//  then the tail is moved and the visited part written
//  reset clears counts and sets max_path to 256; the memories are not cleared
//  results wait in a two-entry buffer; input stalls during a read or merge or when it is full
module path_corridor_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pcm_pkg::pcm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pcm_pkg::pcm_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [8:0]        cfg_data_i
);

  pcm_pkg::pcm_ram_req_t    ram_req;
  logic [pcm_pkg::RefW-1:0] ram_rdata;
  logic                     fifo_full;
  logic                     res_push;
  pcm_pkg::pcm_out_t        res_data;

  assign cfg_ready_o = 1'b1;

  pcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .fifo_full_i (fifo_full),
    .res_push_o  (res_push),
    .res_data_o  (res_data)
  );

  pcm_corridor_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rdata)
  );

  pcm_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_data),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (!fifo_full || (out_valid_o && !out_stall_i)))
    else $error("result buffer overflow");

  a_ram_no_collide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("corridor read and write to the same entry");

  a_merge_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.cmd == pcm_pkg::CMD_PUSH && in_data_i.last)
    |=> in_stall_o)
    else $error("input taken while a merge starts");

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.path_length <= 9'(pcm_pkg::PathDepth)))
    else $error("corridor length beyond depth");

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for path_corridor_merge: directed and random command streams
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int IdlePct = 22;
  localparam int PhaseItems = 130;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  pcm_pkg::pcm_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pcm_pkg::pcm_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [8:0]        cfg_data = '0;

  logic [31:0] corridor_q [pcm_pkg::PathDepth];
  int          corridor_len = 0;
  logic [31:0] visited_q [pcm_pkg::VisDepth];
  int          visited_len = 0;
  logic [8:0]  path_limit = pcm_pkg::MaxPathReset;

  pcm_pkg::pcm_out_t pending_results [$];
  logic [31:0]       ref_pool [8];
  int                errors = 0;
  int unsigned       cycle_count = 0;
  int                items_sent = 0;
  bit                calm = 1'b0;

  path_corridor_merge uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic pcm_pkg::pcm_out_t corridor_predict(input pcm_pkg::pcm_in_t beat);
    pcm_pkg::pcm_out_t res;
    logic [31:0]       spliced [pcm_pkg::PathDepth];
    bit                found;
    int                hit_p, hit_v, head, tail_n, lim, keep;
    res.path_length = '0;
    res.read_ref = '0;
    res.status = pcm_pkg::STAT_OK;
    case (beat.cmd)
      pcm_pkg::CMD_CLEAR: corridor_len = 0;
      pcm_pkg::CMD_APPEND: begin
        if (corridor_len < pcm_pkg::PathDepth) begin
          corridor_q[corridor_len] = beat.poly_ref;
          corridor_len++;
        end else begin
          res.status = pcm_pkg::STAT_PATH_FULL;
        end
      end
      pcm_pkg::CMD_PUSH: begin
        if (visited_len < pcm_pkg::VisDepth) begin
          visited_q[visited_len] = beat.poly_ref;
          visited_len++;
        end else begin
          res.status = pcm_pkg::STAT_VIS_FULL;
        end
        if (beat.last) begin
          found = 1'b0;
          hit_p = 0;
          hit_v = 0;
          // furthest corridor entry, earliest visited match
          for (int i = corridor_len - 1; i >= 0 && !found; i--) begin
            for (int j = 0; j < visited_len && !found; j++) begin
              if (visited_q[j] == corridor_q[i]) begin
                hit_p = i;
                hit_v = j;
                found = 1'b1;
              end
            end
          end
          if (found) begin
            head = visited_len - hit_v;
            tail_n = corridor_len - hit_p - 1;
            lim = (int'(path_limit) > pcm_pkg::PathDepth) ? pcm_pkg::PathDepth
                                                           : int'(path_limit);
            keep = head + tail_n;
            if (keep > lim) keep = lim;
            for (int k = 0; k < keep; k++) begin
              spliced[k] = (k < head) ? visited_q[visited_len - 1 - k]
                                      : corridor_q[hit_p + 1 + k - head];
            end
            for (int k = 0; k < keep; k++) corridor_q[k] = spliced[k];
            corridor_len = keep;
          end else if (res.status == pcm_pkg::STAT_OK) begin
            res.status = pcm_pkg::STAT_NO_COMMON;
          end
          visited_len = 0;
        end
      end
      default: begin
        if (int'(beat.index) < corridor_len) begin
          res.read_ref = corridor_q[beat.index];
        end else begin
          res.status = pcm_pkg::STAT_READ_RANGE;
        end
      end
    endcase
    res.path_length = 9'(corridor_len);
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    if (errors <= 40) begin
      $display("mismatch %s: expected %0h got %0h at cycle %0d", what, want, got, cycle_count);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    pcm_pkg::pcm_out_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) path_limit = cfg_data;
      if (in_valid && !in_stall) pending_results.push_back(corridor_predict(in_data));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report("beat with nothing pending", '0, out_data.read_ref);
        end else begin
          want = pending_results.pop_front();
          if (out_data.path_length !== want.path_length)
            report("path_length", 32'(want.path_length), 32'(out_data.path_length));
          if (out_data.read_ref !== want.read_ref)
            report("read_ref", want.read_ref, out_data.read_ref);
          if (out_data.status !== want.status)
            report("status", 32'(want.status), 32'(out_data.status));
        end
      end
    end
  end

  always @(posedge clk_i) out_stall <= !calm && ($urandom_range(99) < IdlePct);

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb failed");
    $finish;
  end

  task automatic send_beat(input pcm_pkg::pcm_cmd_e op, input logic [31:0] pref,
                           input logic mark, input logic [7:0] idx);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: op, poly_ref: pref, last: mark, index: idx};
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_max_path(input logic [8:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_ref();
    if ($urandom_range(9) == 0) return $urandom();
    return ref_pool[$urandom_range(7)];
  endfunction

  task automatic test_directed();
    send_beat(pcm_pkg::CMD_READ, 32'h0, 1'b1, 8'd0);
    send_beat(pcm_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    send_beat(pcm_pkg::CMD_APPEND, 32'h0, 1'b1, 8'hFF);
    send_beat(pcm_pkg::CMD_APPEND, 32'hFFFF_FFFF, 1'b0, 8'h00);
    send_beat(pcm_pkg::CMD_APPEND, 32'h1234_5678, 1'b0, 8'h00);
    send_beat(pcm_pkg::CMD_READ, 32'hFFFF_FFFF, 1'b0, 8'd2);
    send_beat(pcm_pkg::CMD_READ, 32'h0, 1'b0, 8'd3);
    send_beat(pcm_pkg::CMD_READ, 32'h0, 1'b1, 8'd255);
    // clear leaves a half-collected visited list alone
    send_beat(pcm_pkg::CMD_PUSH, 32'h1234_5678, 1'b0, 8'd0);
    send_beat(pcm_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    send_beat(pcm_pkg::CMD_APPEND, 32'h1234_5678, 1'b0, 8'd0);
    send_beat(pcm_pkg::CMD_APPEND, 32'hA5A5_5A5A, 1'b0, 8'd0);
    send_beat(pcm_pkg::CMD_PUSH, 32'h0BAD_F00D, 1'b1, 8'd0);
    send_beat(pcm_pkg::CMD_READ, 32'h0, 1'b1, 8'd0);
    send_beat(pcm_pkg::CMD_READ, 32'h0, 1'b0, 8'd2);
    // duplicates: furthest corridor entry, earliest visited copy
    send_beat(pcm_pkg::CMD_PUSH, 32'h1234_5678, 1'b0, 8'd0);
    send_beat(pcm_pkg::CMD_PUSH, 32'hA5A5_5A5A, 1'b0, 8'd0);
    send_beat(pcm_pkg::CMD_PUSH, 32'hA5A5_5A5A, 1'b1, 8'd0);
    send_beat(pcm_pkg::CMD_READ, 32'h0, 1'b0, 8'd1);
    send_beat(pcm_pkg::CMD_PUSH, 32'h7777_7777, 1'b1, 8'd0);
    send_beat(pcm_pkg::CMD_CLEAR, 32'h0, 1'b0, 8'd0);
  endtask

  task automatic test_full_corridor();
    logic [31:0] first_ref;
    write_max_path(9'd256);
    first_ref = $urandom();
    send_beat(pcm_pkg::CMD_CLEAR, $urandom(), 1'b0, 8'($urandom()));
    send_beat(pcm_pkg::CMD_APPEND, first_ref, 1'b0, 8'($urandom()));
    for (int k = 1; k < pcm_pkg::PathDepth; k++) begin
      send_beat(pcm_pkg::CMD_APPEND, $urandom(), 1'($urandom_range(1)), 8'($urandom()));
    end
    send_beat(pcm_pkg::CMD_APPEND, 32'hFFFF_FFFF, 1'b0, 8'd0);
    send_beat(pcm_pkg::CMD_APPEND, 32'h0, 1'b1, 8'd0);
    send_beat(pcm_pkg::CMD_READ, 32'h0, 1'b0, 8'd255);
    send_beat(pcm_pkg::CMD_READ, 32'h0, 1'b0, 8'd0);
    // match at the head: the tail moves up and the result is cut to the limit
    send_beat(pcm_pkg::CMD_PUSH, first_ref, 1'b0, 8'd0);
    send_beat(pcm_pkg::CMD_PUSH, $urandom(), 1'b1, 8'd0);
    send_beat(pcm_pkg::CMD_READ, 32'h0, 1'b0, 8'd255);
    send_beat(pcm_pkg::CMD_READ, 32'h0, 1'b0, 8'd1);
    send_beat(pcm_pkg::CMD_PUSH, $urandom(), 1'b1, 8'd0);
    send_beat(pcm_pkg::CMD_CLEAR, 32'h0, 1'b0, 8'd0);
  endtask

  task automatic test_random_phases();
    logic [8:0] limits [8];
    int goal, n_app, n_vis;
    bit broken;
    limits = '{9'd16, 9'd0, 9'd511, 9'd1, 9'd256, 9'd255, 9'd257, 9'd16};
    limits[7] = 9'($urandom_range(256, 16));
    foreach (ref_pool[i]) ref_pool[i] = $urandom();
    foreach (limits[p]) begin
      write_max_path(limits[p]);
      calm = (p == 4);
      goal = items_sent + PhaseItems;
      while (items_sent < goal) begin
        if ($urandom_range(3) == 0) foreach (ref_pool[i]) ref_pool[i] = $urandom();
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(8, 1)) begin
            send_beat(pcm_pkg::pcm_cmd_e'($urandom_range(3)), pick_ref(),
                      1'($urandom_range(1)), 8'($urandom()));
          end
        end else begin
          if ($urandom_range(99) < 80) begin
            send_beat(pcm_pkg::CMD_CLEAR, $urandom(), 1'($urandom_range(1)),
                      8'($urandom()));
          end
          n_app = $urandom_range(24);
          repeat (n_app) begin
            send_beat(pcm_pkg::CMD_APPEND, pick_ref(), 1'($urandom_range(1)),
                      8'($urandom()));
            if ($urandom_range(99) < 15) begin
              send_beat(pcm_pkg::CMD_READ, $urandom(), 1'($urandom_range(1)),
                        8'($urandom_range(n_app + 1)));
            end
          end
          n_vis = ($urandom_range(9) == 0)
                  ? $urandom_range(pcm_pkg::VisDepth + 4, pcm_pkg::VisDepth - 1)
                  : $urandom_range(8, 1);
          broken = ($urandom_range(9) == 0);
          for (int v = 1; v <= n_vis; v++) begin
            send_beat(pcm_pkg::CMD_PUSH, pick_ref(), (v == n_vis) && !broken,
                      8'($urandom()));
          end
          repeat ($urandom_range(3)) begin
            send_beat(pcm_pkg::CMD_READ, $urandom(), 1'($urandom_range(1)),
                      8'($urandom_range(30)));
          end
        end
        if ($urandom_range(5) == 0) drain_results();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_corridor();
    test_random_phases();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
